[hw/rtl/lwcg_pkg.sv]
// Shared types, command codes and color helper for the LCD window command generator.
// Used by every module of the block; depends on nothing.

package lwcg_pkg;

  localparam int PanelBits = 10;
  localparam int WordBits  = 16;
  localparam int IdxBits   = 4;

  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_AREA  = 2'd1;
  localparam logic [1:0] FUNC_DATA  = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  localparam logic [1:0] REG_ROTATION = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;

  localparam logic [15:0] CMD_COL_WIN = 16'h0044;
  localparam logic [15:0] CMD_ROW_WIN = 16'h0045;
  localparam logic [15:0] CMD_CURSOR  = 16'h0021;
  localparam logic [15:0] CMD_WRITE   = 16'h0022;

  localparam logic [5:0] RB_MAX = 6'h1F;
  localparam logic [5:0] G_MAX  = 6'h3F;

  localparam logic [IdxBits-1:0] LAST_IDX = 4'd10;

  typedef struct packed {
    logic [1:0]           rotation;
    logic [PanelBits-1:0] panel_width;
    logic [PanelBits-1:0] panel_height;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] x_start;
    logic signed [15:0] y_start;
    logic signed [15:0] x_end;
    logic signed [15:0] y_end;
    logic [8:0]         red;
    logic [8:0]         green;
    logic [8:0]         blue;
  } item_t;

  typedef struct packed {
    logic                is_data;
    logic [WordBits-1:0] bus_word;
    logic                last;
    logic                rejected;
  } result_t;

  // Saturates a Q1.8 intensity to full scale and maps it onto 0..scale.
  function automatic logic [5:0] chan_scale(input logic [8:0] c, input logic [5:0] scale);
    logic [8:0]  s;
    logic [14:0] p;
    s = (c > 9'd256) ? 9'd256 : c;
    p = {6'b0, s} * {9'b0, scale};
    return p[13:8];
  endfunction

endpackage

[hw/rtl/lwcg_regs.sv]
// APB-style configuration registers: rotation and native panel size.
// Depends on lwcg_pkg for the register indexes and the configuration struct.

module lwcg_regs import lwcg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation     <= 2'd0;
      cfg.panel_width  <= 10'd130;
      cfg.panel_height <= 10'd130;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_ROTATION: cfg.rotation     <= pwdata[1:0];
        REG_WIDTH:    cfg.panel_width  <= pwdata[PanelBits-1:0];
        REG_HEIGHT:   cfg.panel_height <= pwdata[PanelBits-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROTATION: prdata = {30'b0, cfg.rotation};
      REG_WIDTH:    prdata = {22'b0, cfg.panel_width};
      REG_HEIGHT:   prdata = {22'b0, cfg.panel_height};
      default:      prdata = 32'b0;
    endcase
  end

endmodule

[hw/rtl/lwcg_word_gen.sv]
// Forms the bus word at a given position of the sequence for one held request.
// Depends on lwcg_pkg for the command codes, types and color helper.

module lwcg_word_gen import lwcg_pkg::*; (
  input  cfg_t               cfg,
  input  item_t              item,
  input  logic [IdxBits-1:0] idx,
  output result_t            res
);

  logic [15:0]        w16;
  logic [15:0]        h16;
  logic signed [16:0] wv;
  logic signed [16:0] hv;
  logic signed [16:0] xs;
  logic signed [16:0] ys;
  logic signed [16:0] xe;
  logic signed [16:0] ye;
  logic signed [16:0] xs_c;
  logic signed [16:0] ys_c;
  logic signed [16:0] xe_c;
  logic signed [16:0] ye_c;
  logic [15:0]        x0;
  logic [15:0]        y0;
  logic [15:0]        x1;
  logic [15:0]        y1;
  logic [15:0]        a [6];
  logic [5:0]         red_s;
  logic [5:0]         green_s;
  logic [5:0]         blue_s;
  logic [15:0]        colour;
  logic               outside;

  always_comb begin
    w16 = cfg.rotation[0] ? {6'b0, cfg.panel_height} : {6'b0, cfg.panel_width};
    h16 = cfg.rotation[0] ? {6'b0, cfg.panel_width} : {6'b0, cfg.panel_height};
    wv  = $signed({1'b0, w16});
    hv  = $signed({1'b0, h16});
    xs  = {item.x_start[15], item.x_start};
    ys  = {item.y_start[15], item.y_start};
    xe  = {item.x_end[15], item.x_end};
    ye  = {item.y_end[15], item.y_end};

    outside = (xs < 0) || (ys < 0) || (xs >= wv) || (ys >= hv);

    xs_c = (xs < 0) ? 17'sd0 : xs;
    ys_c = (ys < 0) ? 17'sd0 : ys;
    xe_c = (xe < xs_c) ? xs_c : ((xe > wv) ? wv : xe);
    ye_c = (ye < ys_c) ? ys_c : ((ye > hv) ? hv : ye);

    x0 = xs_c[15:0];
    y0 = ys_c[15:0];
    x1 = (item.func == FUNC_AREA) ? xe_c[15:0] : x0;
    y1 = (item.func == FUNC_AREA) ? ye_c[15:0] : y0;

    case (cfg.rotation)
      2'd0: begin
        a[0] = x1 + 16'd2;
        a[1] = x0 + 16'd2;
        a[2] = y1 + 16'd2;
        a[3] = y0 + 16'd2;
        a[4] = y0 + 16'd2;
        a[5] = x0 + 16'd2;
      end
      2'd1: begin
        a[0] = h16 - y0 + 16'd1;
        a[1] = h16 - y1 + 16'd1;
        a[2] = w16 - x0 - 16'd1;
        a[3] = w16 - x1 - 16'd1;
        a[4] = w16 - x0 - 16'd1;
        a[5] = h16 - y0 + 16'd1;
      end
      2'd2: begin
        a[0] = w16 - x0 + 16'd1;
        a[1] = w16 - x1 + 16'd1;
        a[2] = h16 - y0 + 16'd1;
        a[3] = h16 - y1 + 16'd1;
        a[4] = h16 - y0 + 16'd1;
        a[5] = w16 - x0 + 16'd1;
      end
      default: begin
        a[0] = y1 + 16'd2;
        a[1] = y0 + 16'd2;
        a[2] = x1;
        a[3] = x0;
        a[4] = x0;
        a[5] = y0 + 16'd2;
      end
    endcase

    red_s   = chan_scale(item.red, RB_MAX);
    green_s = chan_scale(item.green, G_MAX);
    blue_s  = chan_scale(item.blue, RB_MAX);
    colour  = {red_s[4:0], green_s, blue_s[4:0]};

    res = '0;
    if (item.func == FUNC_DATA) begin
      res.is_data  = 1'b1;
      res.bus_word = colour;
      res.last     = 1'b1;
    end else if (item.func == FUNC_PIXEL && outside) begin
      res.last     = 1'b1;
      res.rejected = 1'b1;
    end else begin
      case (idx)
        4'd0:    res.bus_word = CMD_COL_WIN;
        4'd1:    res.bus_word = a[0];
        4'd2:    res.bus_word = a[1];
        4'd3:    res.bus_word = CMD_ROW_WIN;
        4'd4:    res.bus_word = a[2];
        4'd5:    res.bus_word = a[3];
        4'd6:    res.bus_word = CMD_CURSOR;
        4'd7:    res.bus_word = a[4];
        4'd8:    res.bus_word = a[5];
        4'd9:    res.bus_word = CMD_WRITE;
        default: res.bus_word = (item.func == FUNC_AREA) ? CMD_WRITE : colour;
      endcase
      res.is_data = (idx == 4'd1) || (idx == 4'd2) || (idx == 4'd4) || (idx == 4'd5) ||
                    (idx == 4'd7) || (idx == 4'd8) ||
                    ((idx == LAST_IDX) && (item.func == FUNC_PIXEL));
      res.last    = (idx == LAST_IDX);
    end
  end

endmodule

[hw/rtl/lwcg_out_stage.sv]
// Output register that holds one result until the downstream side takes it.
// Depends on lwcg_pkg for the result struct.

module lwcg_out_stage import lwcg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t din,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t dout
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dout <= din;
    end
  end

endmodule

[hw/rtl/lcd_window_command_generator.sv]
// Top level of the LCD window command generator: request register, word sequencer and output.
// Depends on lwcg_pkg, lwcg_regs, lwcg_word_gen and lwcg_out_stage.

// A request is held in an input register and its words are formed one per cycle, while the
// output register is free, by a sequence counter into the output register. Pixel-data items
// and rejected pixels give one bus word each, pixel or area window requests eleven; the next
// request is accepted in the cycle its last word is transferred into the output register.
// A FUNC_NONE request is accepted and dropped. Configuration must be written over the APB
// port only while no request is in flight; the block itself does not enforce this.

module lcd_window_command_generator import lwcg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic signed [15:0] x_start,
  input  logic signed [15:0] y_start,
  input  logic signed [15:0] x_end,
  input  logic signed [15:0] y_end,
  input  logic [8:0]         red,
  input  logic [8:0]         green,
  input  logic [8:0]         blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_data,
  output logic [15:0]        bus_word,
  output logic               last,
  output logic               rejected
);

  cfg_t               cfg;
  item_t              item;
  logic               hold_valid;
  logic [IdxBits-1:0] idx;
  result_t            gen_res;
  result_t            out_res;
  logic               out_free;
  logic               load;
  logic               in_fire;

  lwcg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lwcg_word_gen u_word_gen (
    .cfg  (cfg),
    .item (item),
    .idx  (idx),
    .res  (gen_res)
  );

  lwcg_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .din       (gen_res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (out_res)
  );

  assign load     = hold_valid && out_free;
  assign in_ready = !hold_valid || (load && gen_res.last);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      idx        <= '0;
    end else if (in_fire) begin
      hold_valid <= (func != FUNC_NONE);
      idx        <= '0;
    end else if (load) begin
      if (gen_res.last) begin
        hold_valid <= 1'b0;
      end
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item.func    <= func;
      item.x_start <= x_start;
      item.y_start <= y_start;
      item.x_end   <= x_end;
      item.y_end   <= y_end;
      item.red     <= red;
      item.green   <= green;
      item.blue    <= blue;
    end
  end

  assign is_data  = out_res.is_data;
  assign bus_word = out_res.bus_word;
  assign last     = out_res.last;
  assign rejected = out_res.rejected;

endmodule

[tb/lcd_window_command_generator_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for lcd_window_command_generator: drives draw requests and
// APB register writes, predicts every bus word and compares it. Depends on lwcg_pkg.

module lcd_window_command_generator_tb;
  import lwcg_pkg::*;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         func;
  logic signed [15:0] x_start;
  logic signed [15:0] y_start;
  logic signed [15:0] x_end;
  logic signed [15:0] y_end;
  logic [8:0]         red;
  logic [8:0]         green;
  logic [8:0]         blue;
  logic               out_valid;
  logic               out_ready;
  logic               is_data;
  logic [15:0]        bus_word;
  logic               last;
  logic               rejected;

  lcd_window_command_generator u_dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_data  (is_data),
    .bus_word (bus_word),
    .last     (last),
    .rejected (rejected)
  );

  logic [1:0] rot_q;
  logic [9:0] pan_w;
  logic [9:0] pan_h;

  result_t words_due[$];
  result_t due_word;

  int mismatches;
  int words_checked;
  int pixels_sent;
  int areas_sent;
  int colours_sent;
  int panel_settings;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  int cfg_rot[8] = '{0, 1, 2, 3, 1, 0, 3, 2};
  int cfg_w[8]   = '{130, 1023, 1, 200, 64, 1023, 7, 333};
  int cfg_h[8]   = '{130, 37, 1023, 90, 1, 1023, 300, 2};
  int idle_snd[4] = '{0, 51, 0, 35};
  int idle_rcv[4] = '{0, 0, 51, 35};

  always #10 clk = ~clk;

  // Color conversion: saturate each channel to full scale, then scale to 5 or 6 bits.
  function automatic int scale_channel(input logic [8:0] c, input int top);
    int v;
    v = (c > 9'd256) ? 256 : int'(c);
    return (v * top) >> 8;
  endfunction

  function automatic logic [15:0] colour_565(input item_t it);
    int r5, g6, b5;
    r5 = scale_channel(it.red, 31);
    g6 = scale_channel(it.green, 63);
    b5 = scale_channel(it.blue, 31);
    return 16'((r5 << 11) | (g6 << 5) | b5);
  endfunction

  function automatic void push_word(input logic dat, input logic [15:0] word,
                                    input logic fin, input logic rej);
    result_t r;
    r.is_data  = dat;
    r.bus_word = word;
    r.last     = fin;
    r.rejected = rej;
    words_due.push_back(r);
  endfunction

  function automatic void push_window(input int x0, input int y0, input int x1, input int y1,
                                      input int w, input int h);
    int a[6];
    case (rot_q)
      2'd0: a = '{x1 + 2, x0 + 2, y1 + 2, y0 + 2, y0 + 2, x0 + 2};
      2'd1: a = '{h - y0 + 1, h - y1 + 1, w - x0 - 1, w - x1 - 1, w - x0 - 1, h - y0 + 1};
      2'd2: a = '{w - x0 + 1, w - x1 + 1, h - y0 + 1, h - y1 + 1, h - y0 + 1, w - x0 + 1};
      default: a = '{y1 + 2, y0 + 2, x1, x0, x0, y0 + 2};
    endcase
    push_word(1'b0, CMD_COL_WIN, 1'b0, 1'b0);
    push_word(1'b1, 16'(a[0]), 1'b0, 1'b0);
    push_word(1'b1, 16'(a[1]), 1'b0, 1'b0);
    push_word(1'b0, CMD_ROW_WIN, 1'b0, 1'b0);
    push_word(1'b1, 16'(a[2]), 1'b0, 1'b0);
    push_word(1'b1, 16'(a[3]), 1'b0, 1'b0);
    push_word(1'b0, CMD_CURSOR, 1'b0, 1'b0);
    push_word(1'b1, 16'(a[4]), 1'b0, 1'b0);
    push_word(1'b1, 16'(a[5]), 1'b0, 1'b0);
    push_word(1'b0, CMD_WRITE, 1'b0, 1'b0);
  endfunction

  function automatic void predict_words(input item_t it);
    int w, h, xs, ys, xe, ye;
    w  = rot_q[0] ? int'(pan_h) : int'(pan_w);
    h  = rot_q[0] ? int'(pan_w) : int'(pan_h);
    xs = int'($signed(it.x_start));
    ys = int'($signed(it.y_start));
    xe = int'($signed(it.x_end));
    ye = int'($signed(it.y_end));
    case (it.func)
      FUNC_PIXEL: begin
        if (xs < 0 || ys < 0 || xs >= w || ys >= h) begin
          push_word(1'b0, 16'h0000, 1'b1, 1'b1);
        end else begin
          push_window(xs, ys, xs, ys, w, h);
          push_word(1'b1, colour_565(it), 1'b1, 1'b0);
        end
      end
      FUNC_AREA: begin
        if (xs < 0) xs = 0;
        if (ys < 0) ys = 0;
        if (xe < xs) xe = xs;
        else if (xe > w) xe = w;
        if (ye < ys) ye = ys;
        else if (ye > h) ye = h;
        push_window(xs, ys, xe, ye, w, h);
        push_word(1'b0, CMD_WRITE, 1'b1, 1'b0);
      end
      FUNC_DATA: push_word(1'b1, colour_565(it), 1'b1, 1'b0);
      default: ;
    endcase
  endfunction

  function automatic item_t make_item(input logic [1:0] f, input int xs, input int ys,
                                      input int xe, input int ye,
                                      input int r, input int g, input int b);
    item_t it;
    it.func    = f;
    it.x_start = 16'(xs);
    it.y_start = 16'(ys);
    it.x_end   = 16'(xe);
    it.y_end   = 16'(ye);
    it.red     = 9'(r);
    it.green   = 9'(g);
    it.blue    = 9'(b);
    return it;
  endfunction

  function automatic int rand_coord(input int lim);
    if ($urandom_range(9) < 2) return int'($urandom & 32'hFFFF);
    return int'($urandom_range(lim + 4)) - 4;
  endfunction

  function automatic int rand_chan();
    if ($urandom_range(9) == 0) return int'($urandom_range(511));
    return int'($urandom_range(256));
  endfunction

  function automatic item_t random_item();
    int sel, w, h;
    logic [1:0] f;
    sel = $urandom_range(99);
    w   = rot_q[0] ? int'(pan_h) : int'(pan_w);
    h   = rot_q[0] ? int'(pan_w) : int'(pan_h);
    f   = (sel < 35) ? FUNC_PIXEL : (sel < 60) ? FUNC_AREA : (sel < 95) ? FUNC_DATA : FUNC_NONE;
    return make_item(f, rand_coord(w), rand_coord(h), rand_coord(w), rand_coord(h),
                     rand_chan(), rand_chan(), rand_chan());
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func     <= it.func;
    x_start  <= it.x_start;
    y_start  <= it.y_start;
    x_end    <= it.x_end;
    y_end    <= it.y_end;
    red      <= it.red;
    green    <= it.green;
    blue     <= it.blue;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_words(it);
    case (it.func)
      FUNC_PIXEL: pixels_sent++;
      FUNC_AREA:  areas_sent++;
      FUNC_DATA:  colours_sent++;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ROTATION: rot_q = val[1:0];
      REG_WIDTH:    pan_w = val[9:0];
      REG_HEIGHT:   pan_h = val[9:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== want) begin
      mismatches++;
      $display("%0t: register %0d read mismatch: expected %h, got %h", $time, idx, want, got);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Registers are written only after every expected word has been checked and the
  // block has gone idle.
  task automatic set_panel(input int rot, input int w, input int h);
    in_valid <= 1'b0;
    while (words_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    apb_write(REG_ROTATION, 32'(rot));
    apb_write(REG_WIDTH, 32'(w));
    apb_write(REG_HEIGHT, 32'(h));
    panel_settings++;
  endtask

  task automatic test_registers();
    set_panel(3, 1023, 1);
    check_register(REG_ROTATION, 32'd3);
    check_register(REG_WIDTH, 32'd1023);
    check_register(REG_HEIGHT, 32'd1);
    set_panel(0, 130, 130);
    check_register(REG_ROTATION, 32'd0);
    check_register(REG_WIDTH, 32'd130);
    check_register(REG_HEIGHT, 32'd130);
  endtask

  task automatic test_pixels();
    send_item(make_item(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(FUNC_PIXEL, 129, 129, 0, 0, 256, 256, 256));
    send_item(make_item(FUNC_PIXEL, 130, 5, 0, 0, 10, 20, 30));
    send_item(make_item(FUNC_PIXEL, 5, 130, 0, 0, 10, 20, 30));
    send_item(make_item(FUNC_PIXEL, -1, 0, 0, 0, 10, 20, 30));
    send_item(make_item(FUNC_PIXEL, 32767, -32768, -1, -1, 511, 511, 511));
    send_item(make_item(FUNC_PIXEL, 64, 64, 0, 0, 511, 300, 255));
  endtask

  task automatic test_areas();
    send_item(make_item(FUNC_AREA, -32768, -3, 32767, 200, 0, 0, 0));
    send_item(make_item(FUNC_AREA, 10, 20, 5, 3, 0, 0, 0));
    send_item(make_item(FUNC_AREA, 200, 140, 300, 10, 0, 0, 0));
    send_item(make_item(FUNC_AREA, 0, 0, 130, 130, 0, 0, 0));
  endtask

  task automatic test_colour_words();
    send_item(make_item(FUNC_DATA, 0, 0, 0, 0, 128, 1, 257));
    send_item(make_item(FUNC_DATA, 0, 0, 0, 0, 255, 255, 255));
    send_item(make_item(FUNC_NONE, 3, 3, 9, 9, 256, 256, 256));
  endtask

  task automatic test_rotations();
    for (int r = 0; r < 4; r++) begin
      set_panel(r, 96, 48);
      send_item(make_item(FUNC_PIXEL, 3, 7, 0, 0, 100, 200, 50));
      send_item(make_item(FUNC_AREA, 2, 1, 40, 50, 0, 0, 0));
    end
  endtask

  task automatic test_empty_panel();
    set_panel(0, 0, 0);
    send_item(make_item(FUNC_PIXEL, 0, 0, 0, 0, 1, 2, 3));
    send_item(make_item(FUNC_AREA, -5, -5, 10, 10, 0, 0, 0));
    send_item(make_item(FUNC_DATA, 0, 0, 0, 0, 31, 63, 31));
  endtask

  task automatic test_random();
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 2; k++) begin
        set_panel(cfg_rot[2 * p + k], cfg_w[2 * p + k], cfg_h[2 * p + k]);
        send_idle_pct  = idle_snd[p];
        recv_stall_pct = idle_rcv[p];
        repeat (8) send_item(random_item());
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    set_panel(1, 130, 90);
    hold_left = 300;
    repeat (15) send_item(make_item(FUNC_DATA, 0, 0, 0, 0, rand_chan(), rand_chan(), 7));
    send_item(make_item(FUNC_PIXEL, 10, 10, 0, 0, 1, 1, 1));
    send_item(make_item(FUNC_AREA, 5, 5, 20, 20, 0, 0, 0));
    repeat (4) send_item(make_item(FUNC_DATA, 0, 0, 0, 0, 256, 0, 256));
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      words_checked++;
      if (words_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transfer: expected none, got is_data=%0b word=%h",
                 $time, is_data, bus_word);
        $display("%0t:           last=%0b rej=%0b", $time, last, rejected);
      end else begin
        due_word = words_due.pop_front();
        if (is_data !== due_word.is_data || bus_word !== due_word.bus_word ||
            last !== due_word.last || rejected !== due_word.rejected) begin
          mismatches++;
          $display("%0t: mismatch: expected is_data=%0b word=%h last=%0b rej=%0b", $time,
                   due_word.is_data, due_word.bus_word, due_word.last, due_word.rejected);
          $display("%0t:           got is_data=%0b word=%h last=%0b rej=%0b", $time,
                   is_data, bus_word, last, rejected);
        end
      end
    end
  end

  initial begin
    #(250_000 * 20);
    $display("lcd_window_command_generator_tb NOT OK");
    $finish;
  end

  initial begin
    int guard;
    clk            = 1'b0;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid       = 1'b0;
    func           = FUNC_DATA;
    x_start        = '0;
    y_start        = '0;
    x_end          = '0;
    y_end          = '0;
    red            = '0;
    green          = '0;
    blue           = '0;
    out_ready      = 1'b0;
    rot_q          = 2'd0;
    pan_w          = 10'd130;
    pan_h          = 10'd130;
    mismatches     = 0;
    words_checked  = 0;
    pixels_sent    = 0;
    areas_sent     = 0;
    colours_sent   = 0;
    panel_settings = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_registers();
    test_pixels();
    test_areas();
    test_colour_words();
    test_rotations();
    test_empty_panel();
    test_random();
    test_backpressure();

    in_valid <= 1'b0;
    guard = 0;
    while (words_due.size() != 0 && guard < 50000) begin
      @(negedge clk);
      guard++;
    end
    repeat (30) @(negedge clk);
    if (words_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected words never arrived", $time, words_due.size());
    end
    $display("Covered %0d pixel, %0d area and %0d color-word requests over %0d panel settings,",
             pixels_sent, areas_sent, colours_sent, panel_settings);
    $display("with %0d bus word transfers checked under sender and receiver stalls.",
             words_checked);
    if (mismatches == 0) begin
      $display("lcd_window_command_generator_tb OK");
    end else begin
      $display("lcd_window_command_generator_tb NOT OK");
    end
    $finish;
  end

endmodule
